// ===== sv/sba_pkg.sv =====
package sba_pkg;

  // Field widths of the request and result items
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFF_W    = 20;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 9;

  // Size classes
  localparam int unsigned MIN_CLASS_LOG2 = 5;
  localparam int unsigned MAX_CLASS_LOG2 = 15;
  localparam int unsigned NUM_CLASSES    = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int unsigned CLS_W          = $clog2(NUM_CLASSES);
  localparam int unsigned LG_W           = 5;

  // Region geometry
  localparam int unsigned PAGE_LOG2         = 12;
  localparam int unsigned DEFAULT_MAX_PAGES = 256;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADOFF  = 2'd3;

endpackage

// ===== sv/size_class_block_allocator.sv =====
// Channel  | handshake                  | payload
// request  | in_valid_i / in_stall_o    | func_i, req_size_i, block_offset_i
// result   | out_valid_o / out_stall_i  | status_o, offset_out_o, class_index_o
// config   | cfg_we_i                   | region_pages_i
//
// One item at a time. Free, bump allocate and every rejected item pass the class
// head read, then the update; a pop from a free list also passes a link step, since
// the link entry named by the head is a second dependent synchronous read.
// Reset and every region_pages write empty all lists and clear the bump pointer;
// the link memory is not cleared (a pop only reads entries a free wrote).
// A stalled result sits in the output register; the next item is still accepted
// and holds at its last step until that register frees up.
module size_class_block_allocator #(
  parameter int unsigned MAX_PAGES = sba_pkg::DEFAULT_MAX_PAGES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         cfg_we_i,
  input  logic [sba_pkg::CFG_W-1:0]    region_pages_i,
  // request
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sba_pkg::FUNC_W-1:0]   func_i,
  input  logic [sba_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [sba_pkg::OFF_W-1:0]    block_offset_i,
  // result
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sba_pkg::STATUS_W-1:0] status_o,
  output logic [sba_pkg::OFF_W-1:0]    offset_out_o,
  output logic [sba_pkg::CLS_W-1:0]    class_index_o
);
  import sba_pkg::*;

  // geometry derived from the region size limit
  localparam int unsigned LINK_DEPTH = (MAX_PAGES << PAGE_LOG2) >> MIN_CLASS_LOG2;
  localparam int unsigned AW         = $clog2(LINK_DEPTH);
  localparam int unsigned PAGES_W    = $clog2(MAX_PAGES + 1);
  localparam int unsigned TOT_W      = PAGES_W + PAGE_LOG2;
  localparam int unsigned SUM_W      =
      ((TOT_W > MAX_CLASS_LOG2 + 1) ? TOT_W : MAX_CLASS_LOG2 + 1) + 2;
  localparam int unsigned CMP_W      = (TOT_W > OFF_W) ? TOT_W : OFF_W;

  // sequencer
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;  // head entry and flag are readable
  localparam logic [1:0] S_LINK = 2'd2;  // link entry of popped block readable

  logic [1:0]         state_q, state_d;

  // config
  logic [PAGES_W-1:0] pages_q;
  logic [TOT_W-1:0]   total;

  // request held while in flight
  logic [FUNC_W-1:0]  func_q;
  logic [OFF_W-1:0]   off_q;
  logic [CLS_W-1:0]   cls_q;
  logic               bad_q;

  logic [TOT_W-1:0]   bump_q, bump_d;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [OFF_W-1:0]    offset_q, offset_d;
  logic [CLS_W-1:0]    cls_out_q;

  logic               in_acc;
  logic               out_free;
  logic               fin;

  logic [CLS_W-1:0]   in_cls;
  logic               in_size_ok;

  // head store
  logic [CLS_W-1:0]   hd_rd_addr;
  logic               hd_we;
  logic               hd_wr_valid;
  logic [AW-1:0]      hd_wr_idx;
  logic               hd_rd_valid;
  logic [AW-1:0]      hd_rd_idx;

  // link memory, entry = {next present, next index}
  logic               lk_we;
  logic [AW-1:0]      lk_waddr;
  logic [AW:0]        lk_wdata;
  logic [AW:0]        lk_rdata;

  // bump and free checks
  logic [LG_W-1:0]    lg;
  logic [SUM_W-1:0]   mask;
  logic [SUM_W-1:0]   aligned;
  logic [SUM_W-1:0]   bump_end;
  logic               no_mem;
  logic               off_bad;
  logic [AW-1:0]      li;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign total = {pages_q, {PAGE_LOG2{1'b0}}};

  sba_size_class u_size_class (
    .req_size_i (req_size_i),
    .cls_o      (in_cls),
    .size_ok_o  (in_size_ok)
  );

  // head read follows the incoming item, then stays on its class
  assign hd_rd_addr = (state_q == S_IDLE) ? in_cls : cls_q;

  sba_head_store #(
    .AW (AW)
  ) u_head_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_we_i),
    .rd_addr_i  (hd_rd_addr),
    .wr_en_i    (hd_we),
    .wr_addr_i  (cls_q),
    .wr_valid_i (hd_wr_valid),
    .wr_idx_i   (hd_wr_idx),
    .rd_valid_o (hd_rd_valid),
    .rd_idx_o   (hd_rd_idx)
  );

  // the link read address is the head index, stable while the item waits
  sba_link_mem #(
    .AW    (AW),
    .DEPTH (LINK_DEPTH),
    .DW    (AW + 1)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .raddr_i (hd_rd_idx),
    .rdata_o (lk_rdata)
  );

  // bump: round up to the block size, then check the block end
  always_comb begin
    lg       = LG_W'(cls_q) + LG_W'(MIN_CLASS_LOG2);
    mask     = (SUM_W'(1) << lg) - SUM_W'(1);
    aligned  = (SUM_W'(bump_q) + mask) & ~mask;
    bump_end = aligned + mask + SUM_W'(1);
    no_mem   = bump_end > SUM_W'(total);
  end

  // free: must be min-block aligned and inside the region
  assign off_bad = (off_q[MIN_CLASS_LOG2-1:0] != '0) || (CMP_W'(off_q) >= CMP_W'(total));
  assign li      = AW'(off_q >> MIN_CLASS_LOG2);

  always_comb begin
    state_d     = state_q;
    fin         = 1'b0;
    status_d    = ST_OK;
    offset_d    = '0;
    bump_d      = bump_q;
    hd_we       = 1'b0;
    hd_wr_valid = 1'b0;
    hd_wr_idx   = li;
    lk_we       = 1'b0;
    lk_waddr    = li;
    lk_wdata    = {hd_rd_valid, hd_rd_idx};
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!bad_q && func_q == FUNC_ALLOC && hd_rd_valid) begin
          state_d = S_LINK;
        end else if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
          if (bad_q) begin
            status_d = ST_BADSIZE;
          end else if (func_q == FUNC_ALLOC) begin
            if (no_mem) begin
              status_d = ST_NOMEM;
            end else begin
              offset_d = OFF_W'(aligned);
              bump_d   = TOT_W'(bump_end);
            end
          end else if (off_bad) begin
            status_d = ST_BADOFF;
          end else begin
            // push: old head becomes the link of the freed block
            lk_we       = 1'b1;
            hd_we       = 1'b1;
            hd_wr_valid = 1'b1;
          end
        end
      end
      S_LINK: begin
        if (out_free) begin
          // pop: the link entry becomes the new head
          fin         = 1'b1;
          state_d     = S_IDLE;
          offset_d    = OFF_W'({hd_rd_idx, {MIN_CLASS_LOG2{1'b0}}});
          hd_we       = 1'b1;
          hd_wr_valid = lk_rdata[AW];
          hd_wr_idx   = lk_rdata[AW-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pages_q     <= '0;
      bump_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pages_q <= (32'(region_pages_i) > MAX_PAGES) ? PAGES_W'(MAX_PAGES)
                                                     : PAGES_W'(region_pages_i);
        bump_q  <= '0;
      end else begin
        bump_q  <= bump_d;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      off_q  <= block_offset_i;
      cls_q  <= in_cls;
      bad_q  <= !in_size_ok || (pages_q == '0);
    end
    if (fin) begin
      status_q  <= status_d;
      offset_q  <= offset_d;
      cls_out_q <= bad_q ? '0 : cls_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign offset_out_o  = offset_q;
  assign class_index_o = cls_out_q;

  // an accepted item always moves to the head step
  a_accept_to_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_HEAD)
    else $error("accepted item did not reach head step");

  // the link step is entered only for an allocation whose list is present
  a_link_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK && $past(state_q) != S_LINK)
      |-> $past(hd_rd_valid && func_q == FUNC_ALLOC && !bad_q))
    else $error("pop started without a list head");

  // the bump pointer never passes the region end
  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= total)
    else $error("bump pointer past region end");

  // only a good allocation returns a nonzero offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> offset_out_o == '0)
    else $error("offset on failed item");

endmodule

// ===== sv/sba_size_class.sv =====
module sba_size_class (
  input  logic [sba_pkg::SIZE_W-1:0] req_size_i,
  output logic [sba_pkg::CLS_W-1:0]  cls_o,
  output logic                       size_ok_o
);
  import sba_pkg::*;

  logic [SIZE_W-1:0] size_m1;
  logic [LG_W-1:0]   bit_len;
  logic [LG_W-1:0]   lg;

  // ceil(log2(size)) is the bit length of size - 1
  always_comb begin
    size_m1 = req_size_i - SIZE_W'(1);
    bit_len = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) begin
        bit_len = LG_W'(i + 1);
      end
    end
    lg = (bit_len < LG_W'(MIN_CLASS_LOG2)) ? LG_W'(MIN_CLASS_LOG2) : bit_len;
  end

  assign size_ok_o = (req_size_i != '0) && (lg <= LG_W'(MAX_CLASS_LOG2));
  assign cls_o     = size_ok_o ? CLS_W'(lg - LG_W'(MIN_CLASS_LOG2)) : '0;

endmodule

// ===== sv/sba_head_store.sv =====
module sba_head_store #(
  parameter int unsigned AW = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic [sba_pkg::CLS_W-1:0] rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [sba_pkg::CLS_W-1:0] wr_addr_i,
  input  logic                      wr_valid_i,
  input  logic [AW-1:0]             wr_idx_i,
  output logic                      rd_valid_o,
  output logic [AW-1:0]             rd_idx_o
);
  import sba_pkg::*;

  logic [AW-1:0]          idx_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] valid_q;
  logic                   rd_valid_q;
  logic [AW-1:0]          rd_idx_q;

  // head index array, synchronous read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      idx_mem[wr_addr_i] <= wr_idx_i;
    end
    rd_idx_q <= idx_mem[rd_addr_i];
  end

  // list-present flags; a config write empties all lists
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= wr_valid_i;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_idx_o   = rd_idx_q;

endmodule

// ===== sv/sba_link_mem.sv =====
module sba_link_mem #(
  parameter int unsigned AW    = 15,
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
